>>> rtl/tec_pkg.sv
`timescale 1ns / 1ps

package tec_pkg;

	// ensemble geometry
	localparam int TREES    = 16;
	localparam int NODES    = 256;
	localparam int FEATURES = 32;

	// field widths fixed by the transaction format
	localparam int POS_W  = 8;
	localparam int WORD_W = 32;
	localparam int FLAG_W = 8;

	localparam int NA_W     = (TREES * NODES > 1) ? $clog2(TREES * NODES) : 1;
	localparam int FA_W     = (FEATURES > 1) ? $clog2(FEATURES) : 1;
	localparam int TC_W     = (TREES > 1) ? $clog2(TREES) : 1;
	localparam int STEP_W   = $clog2(NODES + 1);

	localparam logic [6:0]        IDX_MASK     = 7'h7F;
	localparam int                INTERNAL_BIT = 7;
	localparam logic [WORD_W-1:0] MAG_MASK     = 32'h7FFF_FFFF;

	typedef enum logic [1:0] {
		OP_NODE = 2'd0,
		OP_FEAT = 2'd1,
		OP_RUN  = 2'd2
	} op_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [FLAG_W-1:0] flags;
		logic [POS_W-1:0]  right;
	} node_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_NODE = 4'b0010,
		ST_FEAT = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

endpackage

>>> rtl/tree_ensemble_classifier.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake            Payload
// in       in   in_valid / in_stall  operation, tree_sel, node_sel, node_word, node_flags,
//                                    right_child, feature_slot, feature_bits
// out      out  out_valid / out_stall class_bit, score
//
// Load transactions (node or feature write) each write one entry; out-of-range writes are dropped.
// A run walks the trees in turn; every step of a walk is a node memory read followed by a
// feature memory read, in series, through the single read port of each memory.
// Reset (arst_n low) clears the control; the memories hold nothing defined until written.
// in_stall is high while a run walks the trees or its result waits for the output register.
// A held result in the output register does not block loads.

module tree_ensemble_classifier (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [3:0]  tree_sel,
	input  logic [7:0]  node_sel,
	input  logic [31:0] node_word,
	input  logic [7:0]  node_flags,
	input  logic [7:0]  right_child,
	input  logic [4:0]  feature_slot,
	input  logic [31:0] feature_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        class_bit,
	output logic signed [31:0] score
);
	import tec_pkg::*;

	// sign-magnitude compare: true when feature x is below threshold y, or equals it with a clear sign bit
	function automatic logic goes_left(input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] y);
		logic [WORD_W-1:0] mx;
		logic [WORD_W-1:0] my;
		logic              res;
		mx = x & MAG_MASK;
		my = y & MAG_MASK;
		if (x[WORD_W-1] != y[WORD_W-1]) begin
			res = x[WORD_W-1];
		end else if (!x[WORD_W-1]) begin
			res = (mx <= my);
		end else begin
			res = (mx > my);
		end
		return res;
	endfunction

	// storage: node table and feature table, with registered read data
	node_t             nd_mem [TREES*NODES];
	logic [WORD_W-1:0] ft_mem [FEATURES];

	node_t             nd_rdata_q;
	logic [WORD_W-1:0] ft_rdata_q;

	logic              nd_wr_en, nd_rd_en, ft_wr_en, ft_rd_en;
	logic [NA_W-1:0]   nd_wr_addr, nd_rd_addr;
	logic [FA_W-1:0]   ft_wr_addr, ft_rd_addr;

	// walk control
	state_t             state_q;
	logic [TC_W-1:0]    tree_q;
	logic [STEP_W-1:0]  step_q;
	logic [POS_W-1:0]   pos_q;
	logic [NA_W-1:0]    base_q;
	logic [WORD_W-1:0]  acc_q;
	logic               oob_q;   // current position past the tree
	logic               foob_q;  // feature index past the table

	// output register
	logic               out_valid_q;
	logic               class_q;
	logic [WORD_W-1:0]  score_q;

	logic               in_acc;
	logic               leaf_hit;
	logic               last_tree;
	logic [WORD_W-1:0]  leaf_val;
	logic [WORD_W-1:0]  feat_val;
	logic [POS_W-1:0]   nxt;
	logic               nxt_oob;
	logic [6:0]         fidx;
	logic               fidx_oob;
	logic [WORD_W-1:0]  acc_nxt;
	logic               res_load;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign class_bit = class_q;
	assign score     = signed'(score_q);

	// root always counts as internal; a walk of NODES steps ends where it stands
	assign leaf_hit  = ((step_q != '0) && (!nd_rdata_q.flags[INTERNAL_BIT] || oob_q))
		|| (step_q == STEP_W'(NODES));
	assign last_tree = (tree_q == TC_W'(TREES - 1));
	assign leaf_val  = oob_q ? '0 : nd_rdata_q.word;
	assign acc_nxt   = acc_q + leaf_val;

	assign fidx      = nd_rdata_q.flags[6:0] & IDX_MASK;
	assign fidx_oob  = (32'(fidx) >= FEATURES);
	assign feat_val  = foob_q ? '0 : ft_rdata_q;

	assign nxt       = goes_left(feat_val, nd_rdata_q.word) ? pos_q + POS_W'(1) : nd_rdata_q.right;
	assign nxt_oob   = (32'(nxt) >= NODES);

	// finished sum moves into the output register once that is free or draining
	assign res_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		nd_wr_en   = 1'b0;
		nd_wr_addr = NA_W'(32'(tree_sel) * NODES + 32'(node_sel));
		ft_wr_en   = 1'b0;
		ft_wr_addr = FA_W'(feature_slot);
		nd_rd_en   = 1'b0;
		nd_rd_addr = base_q + NA_W'(nxt);
		ft_rd_en   = 1'b0;
		ft_rd_addr = FA_W'(fidx);
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (operation)
						OP_NODE: nd_wr_en = (32'(tree_sel) < TREES) && (32'(node_sel) < NODES);
						OP_FEAT: ft_wr_en = (32'(feature_slot) < FEATURES);
						OP_RUN: begin
							nd_rd_en   = 1'b1;
							nd_rd_addr = '0;
						end
						default: ;
					endcase
				end
			end
			ST_NODE: begin
				if (leaf_hit) begin
					nd_rd_en   = !last_tree;
					nd_rd_addr = base_q + NA_W'(NODES);
				end else begin
					ft_rd_en = !fidx_oob;
				end
			end
			ST_FEAT: nd_rd_en = !nxt_oob;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (nd_wr_en) begin
			nd_mem[nd_wr_addr] <= '{word: node_word, flags: node_flags, right: right_child};
		end
		if (nd_rd_en) begin
			nd_rdata_q <= nd_mem[nd_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ft_wr_en) begin
			ft_mem[ft_wr_addr] <= feature_bits;
		end
		if (ft_rd_en) begin
			ft_rdata_q <= ft_mem[ft_rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			tree_q      <= '0;
			step_q      <= '0;
			pos_q       <= '0;
			base_q      <= '0;
			acc_q       <= '0;
			oob_q       <= 1'b0;
			foob_q      <= 1'b0;
			class_q     <= 1'b0;
			score_q     <= '0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && operation == OP_RUN) begin
						state_q <= ST_NODE;
						tree_q  <= '0;
						step_q  <= '0;
						pos_q   <= '0;
						base_q  <= '0;
						acc_q   <= '0;
						oob_q   <= 1'b0;
					end
				end
				ST_NODE: begin
					if (leaf_hit) begin
						acc_q <= acc_nxt;
						if (last_tree) begin
							state_q <= ST_DONE;
						end else begin
							tree_q <= tree_q + TC_W'(1);
							base_q <= base_q + NA_W'(NODES);
							step_q <= '0;
							pos_q  <= '0;
							oob_q  <= 1'b0;
						end
					end else begin
						foob_q  <= fidx_oob;
						state_q <= ST_FEAT;
					end
				end
				ST_FEAT: begin
					pos_q   <= nxt;
					oob_q   <= nxt_oob;
					step_q  <= step_q + STEP_W'(1);
					state_q <= ST_NODE;
				end
				ST_DONE: begin
					// wait for the output register to free up
					if (res_load) begin
						score_q <= acc_q;
						class_q <= (acc_q != '0) && !acc_q[WORD_W-1];
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// walk length never passes the node count
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_W'(NODES))
		else $error("walk step count out of range");

	// a run transaction starts at the root of the first tree
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && operation == OP_RUN |=> state_q == ST_NODE && tree_q == '0 && step_q == '0)
		else $error("run did not start at first root");

	// a finished result is not dropped while the output register is held
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_valid_q && out_stall |=> state_q == ST_DONE)
		else $error("result overwrote a held transaction");

	// no load can hit the node table while a walk reads it
	a_no_rw_mix: assert property (@(posedge clk) disable iff (!arst_n)
		nd_wr_en |-> state_q == ST_IDLE && !nd_rd_en)
		else $error("node write during walk");

	// a feature read only follows an internal node
	a_feat_seq: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FEAT |-> $past(state_q) == ST_NODE && $past(!leaf_hit))
		else $error("feature stage entered without internal node");

endmodule
